// ===== hw/rtl/pmpta_pkg.sv =====
// Package for the polynomial term accumulator: widths, command and status codes.
// No dependencies; used by the interfaces and by every module of the block but the coefficient RAM.
`timescale 1ns / 1ps

package pmpta_pkg;

    localparam int MAX_TERMS = 256;
    localparam int DEG_W     = $clog2(MAX_TERMS);
    localparam int LEN_W     = DEG_W + 1;
    localparam int COEF_W    = 8;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;

    // length tree: groups of 16 mask bits
    localparam int GRP_W     = 4;
    localparam int GRP_SIZE  = 1 << GRP_W;
    localparam int NGRP      = MAX_TERMS / GRP_SIZE;
    localparam int NGRP_W    = DEG_W - GRP_W;

    // modulo unit: two quotient bits per cycle
    localparam int MOD_CYC   = COEF_W / 2;
    localparam int MOD_CNT_W = $clog2(MOD_CYC);

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_NEGATIVE = 2'd2;

endpackage

// ===== hw/rtl/pmpta_if.sv =====
// Channel interfaces of the polynomial term accumulator: term, result, config.
// Depends on pmpta_pkg.
`timescale 1ns / 1ps

interface pmpta_term_if import pmpta_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [DEG_W-1:0]  term_degree;
    logic [COEF_W-1:0] term_value;

    modport source(output valid, output command, output term_degree, output term_value,
                   input ready);
    modport sink(input valid, input command, input term_degree, input term_value,
                 output ready);
endinterface

interface pmpta_res_if import pmpta_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [COEF_W-1:0] coefficient;
    logic [LEN_W-1:0]  length;

    modport source(output valid, output status, output coefficient, output length,
                   input ready);
    modport sink(input valid, input status, input coefficient, input length,
                 output ready);
endinterface

interface pmpta_cfg_if import pmpta_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [COEF_W-1:0] field_order;

    modport source(output valid, output field_order, input ready);
    modport sink(input valid, input field_order, output ready);
endinterface

// ===== hw/rtl/pmpta_coef_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Holds the coefficient store; no dependencies.
`timescale 1ns / 1ps

module pmpta_coef_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pmpta_mod_unit.sv =====
// Iterative 8-bit remainder unit, restoring division, two bits per cycle.
// Depends on pmpta_pkg.
`timescale 1ns / 1ps

module pmpta_mod_unit import pmpta_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [COEF_W-1:0] i_dividend,
    input  logic [COEF_W-1:0] i_divisor,
    output logic [COEF_W-1:0] o_remainder,
    output logic              o_done
);

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [COEF_W-1:0]    r_rem;
    logic [COEF_W-1:0]    r_shift;
    logic [COEF_W-1:0]    r_div;
    logic [COEF_W-1:0]    w_mid;
    logic [COEF_W-1:0]    w_next;

    function automatic logic [COEF_W-1:0] rem_step(input logic [COEF_W-1:0] rem,
                                                   input logic bitin,
                                                   input logic [COEF_W-1:0] d);
        logic [COEF_W:0] t;
        t = {rem, bitin};
        if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
        end
        return t[COEF_W-1:0];
    endfunction

    assign w_mid  = rem_step(r_rem, r_shift[COEF_W-1], r_div);
    assign w_next = rem_step(w_mid, r_shift[COEF_W-2], r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_rem   <= '0;
                r_shift <= i_dividend;
                r_div   <= i_divisor;
            end else if (r_busy) begin
                r_rem   <= w_next;
                r_shift <= {r_shift[COEF_W-3:0], 2'b00};
                r_cnt   <= r_cnt + 1'b1;
                if (r_cnt == MOD_CNT_W'(MOD_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_remainder = r_rem;
    assign o_done      = r_done;

endmodule

// ===== hw/rtl/pmpta_len_tree.sv =====
// Two-stage registered search for the highest set bit of the nonzero mask.
// Output is that degree plus one, or zero; depends on pmpta_pkg.
`timescale 1ns / 1ps

module pmpta_len_tree import pmpta_pkg::*; (
    input  logic                 i_clk,
    input  logic [MAX_TERMS-1:0] i_nz,
    output logic [LEN_W-1:0]     o_length
);

    logic [NGRP-1:0]  n_any;
    logic [GRP_W-1:0] n_hi [NGRP];
    logic [NGRP-1:0]  r_any;
    logic [GRP_W-1:0] r_hi [NGRP];
    logic             w_found;
    logic [DEG_W-1:0] w_sel;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] r_len;

    // stage 1: per-group any bit and highest index
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_any[g] = |i_nz[g*GRP_SIZE +: GRP_SIZE];
            n_hi[g]  = '0;
            for (int b = 0; b < GRP_SIZE; b++) begin
                if (i_nz[g*GRP_SIZE + b]) begin
                    n_hi[g] = GRP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_any <= n_any;
        for (int g = 0; g < NGRP; g++) begin
            r_hi[g] <= n_hi[g];
        end
    end

    // stage 2: highest nonempty group
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (r_any[g]) begin
                w_found = 1'b1;
                w_sel   = {NGRP_W'(g), r_hi[g]};
            end
        end
        n_len = w_found ? ({1'b0, w_sel} + 1'b1) : '0;
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    assign o_length = r_len;

endmodule

// ===== hw/rtl/poly_mod_p_term_accumulator.sv =====
// Polynomial term accumulator over GF(p) or plain unsigned 8-bit coefficients.
// A term is taken only in the idle state, after the result of the last term has been registered.
// Each term passes through the 4-step remainder units and the 2-stage length tree.
// Reset (sync, active low) clears the nonzero mask, so all coefficients read as zero,
// and sets field_order to 0. Depends on pmpta_pkg, pmpta_if and the submodules.
`timescale 1ns / 1ps

module poly_mod_p_term_accumulator import pmpta_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pmpta_term_if.sink i_term,
    pmpta_res_if.source o_res,
    pmpta_cfg_if.sink  i_cfg
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_LEN1  = 3'd4;
    localparam logic [2:0] S_LEN2  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [COEF_W-1:0]    r_field_order;
    logic [CMD_W-1:0]     r_cmd;
    logic [DEG_W-1:0]     r_deg;
    logic [COEF_W-1:0]    r_val;
    logic [COEF_W-1:0]    r_cur;
    logic [MAX_TERMS-1:0] r_nz;
    logic [STAT_W-1:0]    r_stat;
    logic [COEF_W-1:0]    r_coef;
    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_out_stat;
    logic [COEF_W-1:0]    r_out_coef;
    logic [LEN_W-1:0]     r_out_len;

    logic                 w_accept;
    logic                 w_out_free;
    logic [COEF_W-1:0]    w_rdata;
    logic [COEF_W-1:0]    w_cur;
    logic [COEF_W-1:0]    w_v;
    logic [COEF_W-1:0]    w_c;
    logic                 w_mod_done;
    logic                 w_cur_done;
    logic [LEN_W-1:0]     w_length;
    logic                 w_present;
    logic                 w_add;
    logic [COEF_W:0]      w_msum;
    logic [COEF_W:0]      w_psum;
    logic                 w_we;
    logic [COEF_W-1:0]    w_wdata;
    logic [STAT_W-1:0]    n_stat;
    logic [COEF_W-1:0]    n_coef;

    assign w_accept    = i_term.valid && i_term.ready;
    assign i_term.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_out_free   = !r_out_valid || o_res.ready;

    pmpta_coef_ram #(
        .DATA_W(COEF_W),
        .ADDR_W(DEG_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we && (r_state == S_WRITE)),
        .i_waddr(r_deg),
        .i_wdata(w_wdata),
        .i_re   (w_accept),
        .i_raddr(i_term.term_degree),
        .o_rdata(w_rdata)
    );

    // a clear mask bit means the entry holds zero
    assign w_cur = r_nz[r_deg] ? w_rdata : '0;

    pmpta_mod_unit u_mod_val (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_READ),
        .i_dividend (r_val),
        .i_divisor  (r_field_order),
        .o_remainder(w_v),
        .o_done     (w_mod_done)
    );

    pmpta_mod_unit u_mod_cur (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_READ),
        .i_dividend (w_cur),
        .i_divisor  (r_field_order),
        .o_remainder(w_c),
        .o_done     (w_cur_done)
    );

    pmpta_len_tree u_len (
        .i_clk   (i_clk),
        .i_nz    (r_nz),
        .o_length(w_length)
    );

    // update of the selected coefficient
    always_comb begin
        w_present = (r_cur != '0);
        w_add     = (r_cmd == CMD_ADD);
        w_msum    = {1'b0, w_c} + {1'b0, w_v};
        if (w_msum >= {1'b0, r_field_order}) begin
            w_msum = w_msum - {1'b0, r_field_order};
        end
        w_psum  = {1'b0, r_cur} + {1'b0, r_val};
        n_stat  = ST_OK;
        w_we    = 1'b0;
        w_wdata = r_cur;
        case (r_cmd)
            CMD_ADD, CMD_SUB: begin
                if (r_field_order != '0) begin
                    if (w_v != '0) begin
                        w_we = 1'b1;
                        if (w_present) begin
                            if (w_add) begin
                                w_wdata = w_msum[COEF_W-1:0];
                            end else if (w_c >= w_v) begin
                                w_wdata = w_c - w_v;
                            end else begin
                                w_wdata = r_field_order + w_c - w_v;
                            end
                        end else begin
                            w_wdata = w_add ? w_v : (r_field_order - w_v);
                        end
                    end
                end else if (r_val != '0) begin
                    if (w_add) begin
                        if (w_psum[COEF_W]) begin
                            n_stat = ST_OVERFLOW;
                        end else begin
                            w_we    = 1'b1;
                            w_wdata = w_psum[COEF_W-1:0];
                        end
                    end else if (!w_present || (r_cur < r_val)) begin
                        n_stat = ST_NEGATIVE;
                    end else begin
                        w_we    = 1'b1;
                        w_wdata = r_cur - r_val;
                    end
                end
            end
            default: ;
        endcase
        if (r_cmd == CMD_CLEAR) begin
            n_coef = '0;
        end else begin
            n_coef = w_we ? w_wdata : r_cur;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_READ;
            S_READ:  n_state = S_MOD;
            S_MOD:   if (w_mod_done) n_state = S_WRITE;
            S_WRITE: n_state = S_LEN1;
            S_LEN1:  n_state = S_LEN2;
            S_LEN2:  n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_field_order <= '0;
            r_nz          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_field_order <= i_cfg.field_order;
            end
            if (r_state == S_WRITE) begin
                if (r_cmd == CMD_CLEAR) begin
                    r_nz <= '0;
                end else if (w_we) begin
                    r_nz[r_deg] <= (w_wdata != '0);
                end
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_term.command;
            r_deg <= i_term.term_degree;
            r_val <= i_term.term_value;
        end
        if (r_state == S_READ) begin
            r_cur <= w_cur;
        end
        if (r_state == S_WRITE) begin
            r_stat <= n_stat;
            r_coef <= n_coef;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_stat <= r_stat;
            r_out_coef <= r_coef;
            r_out_len  <= w_length;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_stat;
    assign o_res.coefficient = r_out_coef;
    assign o_res.length      = r_out_len;

    // both remainder units run in lockstep
    a_mod_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done == w_cur_done)
        else $error("remainder units out of step");

    a_mod_done_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_MOD))
        else $error("remainder done outside of modulo wait");

    a_modular_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) && (r_field_order != '0)) |-> (n_stat == ST_OK))
        else $error("status flagged in modular mode");

    a_clear_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) && (r_cmd == CMD_CLEAR)) |=> (r_nz == '0))
        else $error("clear left mask bits set");

    a_mask_tracks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WRITE) && w_we && (r_cmd != CMD_CLEAR))
        |=> (r_nz[$past(r_deg)] == ($past(w_wdata) != '0)))
        else $error("mask bit does not match written coefficient");

endmodule
